// ----- rtl/fgph_pkg.sv -----
// ----------------------------------------------------------------------------
// fgph_pkg: shared definitions for the freshness-gated path holder
// Item kinds, result flag group, register map and default widths.
// ----------------------------------------------------------------------------
package fgph_pkg;

   localparam int TIME_BITS_DEF   = 48;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int GEN_BITS_DEF    = 32;

   // Timeout register value after reset, in ticks.
   localparam logic [63:0] TIMEOUT_RESET = 64'd1000000000;

   // Register file: 64-bit registers at byte address 8*i.
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int CSR_OFFSET_BITS = 3;
   localparam int CSR_INDEX_BITS  = CSR_ADDR_BITS - CSR_OFFSET_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT = '0;

   typedef enum logic [1:0] {
      KIND_SNAPSHOT = 2'd0,
      KIND_VALIDITY = 2'd1,
      KIND_CHECK    = 2'd2,
      KIND_READ     = 2'd3
   } kind_type;

   typedef struct packed {
      logic invalidated;
      logic stale_drop;
      logic activated;
      logic out_present;
      logic validity_seen;
      logic validity_set;
   } rsp_flags_type;

endpackage

// ----- rtl/fgph_if.sv -----
// ----------------------------------------------------------------------------
// fgph_if: request and response channels of the path holder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fgph_req_if #(
   parameter int TIME_BITS   = fgph_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = fgph_pkg::HANDLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   fgph_pkg::kind_type     kind;
   logic [TIME_BITS-1:0]   timestamp;
   logic                   valid_flag;
   logic                   handle_present;
   logic [HANDLE_BITS-1:0] handle_id;

   modport source (output valid, kind, timestamp, valid_flag, handle_present, handle_id,
                   input ready);
   modport sink   (input valid, kind, timestamp, valid_flag, handle_present, handle_id,
                   output ready);
endinterface

interface fgph_rsp_if #(
   parameter int HANDLE_BITS = fgph_pkg::HANDLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   invalidated;
   logic                   stale_drop;
   logic                   activated;
   logic                   out_present;
   logic [HANDLE_BITS-1:0] out_id;
   logic                   validity_seen;
   logic                   validity_set;

   modport source (output valid, invalidated, stale_drop, activated, out_present,
                   out_id, validity_seen, validity_set,
                   input ready);
   modport sink   (input valid, invalidated, stale_drop, activated, out_present,
                   out_id, validity_seen, validity_set,
                   output ready);
endinterface

// ----- rtl/fgph_csr.sv -----
// ----------------------------------------------------------------------------
// fgph_csr: configuration registers of the path holder
// APB-style slave holding the validity timeout, always ready.
// ----------------------------------------------------------------------------
module fgph_csr #(
   parameter int TIME_BITS = fgph_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fgph_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [fgph_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [fgph_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready,
   output logic [TIME_BITS-1:0]               timeout
);

   logic [fgph_pkg::CSR_INDEX_BITS-1:0] index;
   logic                                wr_timeout;
   logic [TIME_BITS-1:0]                timeout_ff;

   assign index      = paddr[fgph_pkg::CSR_ADDR_BITS-1:fgph_pkg::CSR_OFFSET_BITS];
   assign wr_timeout = psel && penable && pwrite && (index == fgph_pkg::REG_TIMEOUT);
   assign pready     = 1'b1;
   assign timeout    = timeout_ff;

   always_comb begin
      prdata = '0;
      if (index == fgph_pkg::REG_TIMEOUT) begin
         prdata = fgph_pkg::CSR_DATA_BITS'(timeout_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIME_BITS'(fgph_pkg::TIMEOUT_RESET);
      end else if (wr_timeout) begin
         timeout_ff <= pwdata[TIME_BITS-1:0];
      end
   end

endmodule

// ----- rtl/fgph_core.sv -----
// ----------------------------------------------------------------------------
// fgph_core: handle and validity state with its update logic
// Evaluates freshness, invalidation and promotion for one request per cycle while step is high.
// ----------------------------------------------------------------------------
module fgph_core #(
   parameter int TIME_BITS   = fgph_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = fgph_pkg::HANDLE_BITS_DEF,
   parameter int GEN_BITS    = fgph_pkg::GEN_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  fgph_pkg::kind_type      kind,
   input  logic [TIME_BITS-1:0]    now,
   input  logic                    flag,
   input  logic                    present,
   input  logic [HANDLE_BITS-1:0]  id,
   input  logic [TIME_BITS-1:0]    timeout,
   output fgph_pkg::rsp_flags_type flags,
   output logic [HANDLE_BITS-1:0]  out_id
);

   logic                   seen_ff, seen_in;
   logic                   val_ff, val_in;
   logic [TIME_BITS-1:0]   lvt_ff, lvt_in;
   logic                   ever_ff, ever_in;
   logic [GEN_BITS-1:0]    gen_ff, gen_in;
   logic                   ap_ff, ap_in;
   logic [HANDLE_BITS-1:0] ah_ff, ah_in;
   logic                   pp_ff, pp_in;
   logic [HANDLE_BITS-1:0] ph_ff, ph_in;
   logic [GEN_BITS-1:0]    pg_ff, pg_in;

   logic [TIME_BITS-1:0]   age;
   logic                   fresh;
   logic                   was_true;
   logic                   want_drop;
   logic                   real_drop;
   logic                   promote_ok;
   logic [HANDLE_BITS-1:0] id_m;

   assign age      = now - lvt_ff;
   assign was_true = seen_ff && val_ff;
   assign fresh    = was_true && (now >= lvt_ff) && (age <= timeout);
   assign id_m     = present ? id : '0;

   // A false validity always drops; any other kind drops only on stale validity.
   assign want_drop = (was_true && !fresh) || ((kind == fgph_pkg::KIND_VALIDITY) && !flag);
   // With nothing held, validity already false and an earlier drop done,
   // the drop only clears the validity value and is not counted.
   assign real_drop = want_drop && (ap_ff || pp_ff || was_true || !ever_ff);

   always_comb begin
      seen_in    = seen_ff;
      val_in     = val_ff;
      lvt_in     = lvt_ff;
      ever_in    = ever_ff;
      gen_in     = gen_ff;
      ap_in      = ap_ff;
      ah_in      = ah_ff;
      pp_in      = pp_ff;
      ph_in      = ph_ff;
      pg_in      = pg_ff;
      flags      = '0;
      out_id     = '0;
      promote_ok = 1'b0;

      if (want_drop) begin
         val_in = 1'b0;
      end
      if (real_drop) begin
         ap_in   = 1'b0;
         ah_in   = '0;
         pp_in   = 1'b0;
         ph_in   = '0;
         ever_in = 1'b1;
         gen_in  = gen_ff + 1'b1;
         pg_in   = '0;
      end
      promote_ok = pp_in && (pg_in == gen_in);

      case (kind)
         fgph_pkg::KIND_SNAPSHOT: begin
            if (fresh) begin
               ap_in = present;
               ah_in = id_m;
               pp_in = 1'b0;
               ph_in = '0;
               pg_in = '0;
            end else begin
               pp_in = present;
               ph_in = id_m;
               pg_in = gen_in;
               ap_in = 1'b0;
               ah_in = '0;
            end
         end
         fgph_pkg::KIND_VALIDITY: begin
            seen_in = 1'b1;
            lvt_in  = now;
            if (flag) begin
               val_in           = 1'b1;
               flags.stale_drop = real_drop;
               if (promote_ok) begin
                  ap_in          = 1'b1;
                  ah_in          = ph_in;
                  pp_in          = 1'b0;
                  ph_in          = '0;
                  pg_in          = '0;
                  flags.activated = 1'b1;
               end
            end
         end
         fgph_pkg::KIND_CHECK: begin
         end
         fgph_pkg::KIND_READ: begin
            if (fresh) begin
               if (promote_ok) begin
                  ap_in = 1'b1;
                  ah_in = ph_in;
                  pp_in = 1'b0;
                  ph_in = '0;
                  pg_in = '0;
               end
               flags.out_present = ap_in;
               out_id            = ap_in ? ah_in : '0;
            end
         end
         default: begin
         end
      endcase

      flags.invalidated   = real_drop;
      flags.validity_seen = seen_in;
      flags.validity_set  = val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         val_ff  <= 1'b0;
         lvt_ff  <= '0;
         ever_ff <= 1'b0;
         gen_ff  <= '0;
         ap_ff   <= 1'b0;
         ah_ff   <= '0;
         pp_ff   <= 1'b0;
         ph_ff   <= '0;
         pg_ff   <= '0;
      end else if (step) begin
         seen_ff <= seen_in;
         val_ff  <= val_in;
         lvt_ff  <= lvt_in;
         ever_ff <= ever_in;
         gen_ff  <= gen_in;
         ap_ff   <= ap_in;
         ah_ff   <= ah_in;
         pp_ff   <= pp_in;
         ph_ff   <= ph_in;
         pg_ff   <= pg_in;
      end
   end

endmodule

// ----- rtl/freshness_gated_path_holder_top.sv -----
// ----------------------------------------------------------------------------
// freshness_gated_path_holder_top: freshness-gated active/pending handle holder
// Input register, state update and a registered response.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_ch (valid/ready). Each carries a kind (snapshot,
//   validity event, staleness check or consumer read), a timestamp and the
//   snapshot handle. Every request yields exactly one response on rsp_ch.
//   The validity timeout is set through the csr_ APB port (register 0 at
//   byte address 0) while no request is in flight.
//   A request accepted on req_ch is captured in the input register; when the
//   response register is free or being taken, it updates the state and loads
//   the response register, which raises rsp_ch.valid. Throughput is one
//   request per cycle while the receiver takes every response.
//   When the receiver stalls, the response holds, one more request waits
//   in the input register, and req_ch.ready then drops until the response
//   is taken.
//   Reset clears all handles, validity, the generation count and both
//   pipeline stages, and loads the timeout with its default of 1e9 ticks.
// ----------------------------------------------------------------------------
module freshness_gated_path_holder_top #(
   parameter int TIME_BITS   = fgph_pkg::TIME_BITS_DEF,
   parameter int HANDLE_BITS = fgph_pkg::HANDLE_BITS_DEF,
   parameter int GEN_BITS    = fgph_pkg::GEN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   fgph_req_if.sink                           req_ch,
   fgph_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fgph_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fgph_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fgph_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic [TIME_BITS-1:0]    timeout;

   logic                    in_valid_ff, in_valid_in;
   fgph_pkg::kind_type      in_kind_ff;
   logic [TIME_BITS-1:0]    in_time_ff;
   logic                    in_flag_ff;
   logic                    in_present_ff;
   logic [HANDLE_BITS-1:0]  in_id_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   fgph_pkg::rsp_flags_type rsp_flags_ff;
   logic [HANDLE_BITS-1:0]  rsp_id_ff;

   fgph_pkg::rsp_flags_type core_flags;
   logic [HANDLE_BITS-1:0]  core_id;

   logic                    req_fire;
   logic                    advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   fgph_csr #(
      .TIME_BITS (TIME_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .timeout (timeout)
   );

   fgph_core #(
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .GEN_BITS    (GEN_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .kind    (in_kind_ff),
      .now     (in_time_ff),
      .flag    (in_flag_ff),
      .present (in_present_ff),
      .id      (in_id_ff),
      .timeout (timeout),
      .flags   (core_flags),
      .out_id  (core_id)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff    <= req_ch.kind;
         in_time_ff    <= req_ch.timestamp;
         in_flag_ff    <= req_ch.valid_flag;
         in_present_ff <= req_ch.handle_present;
         in_id_ff      <= req_ch.handle_id;
      end
      if (advance) begin
         rsp_flags_ff <= core_flags;
         rsp_id_ff    <= core_id;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.invalidated   = rsp_flags_ff.invalidated;
   assign rsp_ch.stale_drop    = rsp_flags_ff.stale_drop;
   assign rsp_ch.activated     = rsp_flags_ff.activated;
   assign rsp_ch.out_present   = rsp_flags_ff.out_present;
   assign rsp_ch.out_id        = rsp_id_ff;
   assign rsp_ch.validity_seen = rsp_flags_ff.validity_seen;
   assign rsp_ch.validity_set  = rsp_flags_ff.validity_set;

`ifndef SYNTHESIS
   // A queued request must reach the response register when it is empty.
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("queued request did not produce a response");

   // A handle is only returned under fresh, true validity.
   a_present_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.out_present |->
         rsp_flags_ff.validity_set && rsp_flags_ff.validity_seen)
      else $error("handle returned without true validity");

   // A stale drop on a validity event is always a real drop.
   a_stale_is_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.stale_drop |-> rsp_flags_ff.invalidated)
      else $error("stale invalidation not counted as invalidation");

   // A drop clears the pending handle, so nothing can be promoted with it.
   a_no_promote_after_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.activated |-> !rsp_flags_ff.invalidated)
      else $error("promotion in the same request as an invalidation");

   a_null_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_flags_ff.out_present |-> rsp_id_ff == '0)
      else $error("nonzero handle id without a returned handle");
`endif

endmodule

// ----- tb/freshness_gated_path_holder_top_tb.sv -----
// ----------------------------------------------------------------------------
// freshness_gated_path_holder_top_tb: self-checking bench for the path holder
// A directed table of requests checks reset behavior, the timeout boundary
// and redundant drops. Random phases follow; all but the first write a timeout. An
// in-bench model of the handle state predicts every response, and the
// responses are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module freshness_gated_path_holder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W      = fgph_pkg::TIME_BITS_DEF;
   localparam int HANDLE_W    = fgph_pkg::HANDLE_BITS_DEF;
   localparam int GEN_W       = fgph_pkg::GEN_BITS_DEF;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 140;
   localparam int LONG_STALL  = 80;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [fgph_pkg::CSR_ADDR_BITS-1:0] TIMEOUT_ADDR =
      {fgph_pkg::REG_TIMEOUT, {fgph_pkg::CSR_OFFSET_BITS{1'b0}}};

   typedef struct packed {
      fgph_pkg::kind_type    kind;
      logic [TIME_W-1:0]     timestamp;
      logic                  valid_flag;
      logic                  handle_present;
      logic [HANDLE_W-1:0]   handle_id;
   } holder_req_type;

   typedef struct packed {
      fgph_pkg::rsp_flags_type flags;
      logic [HANDLE_W-1:0]     out_id;
   } holder_result_type;

   typedef struct {
      holder_req_type    rq;
      bit                typed;
      holder_result_type rsp;
   } stim_row_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [fgph_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [fgph_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [fgph_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   fgph_req_if req_if ();
   fgph_rsp_if rsp_if ();

   freshness_gated_path_holder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   holder_result_type expected_rsps[$];
   stim_row_type      stim_table[$];
   int                fail_count   = 0;
   bit                idle_on      = 1'b1;
   bit                rx_long_stall = 1'b0;

   // Model of the holder state.
   bit                  st_seen, st_val, st_ever_inv, st_act_pres, st_pend_pres;
   logic [TIME_W-1:0]   st_last_time = '0;
   logic [TIME_W-1:0]   st_timeout = fgph_pkg::TIMEOUT_RESET[TIME_W-1:0];
   logic [GEN_W-1:0]    st_gen = '0;
   logic [GEN_W-1:0]    st_pend_gen = '0;
   logic [HANDLE_W-1:0] st_act_id = '0;
   logic [HANDLE_W-1:0] st_pend_id = '0;

   function automatic bit fresh_at(logic [TIME_W-1:0] now);
      if (!st_seen || !st_val) return 1'b0;
      if (now < st_last_time) return 1'b0;
      return (now - st_last_time) <= st_timeout;
   endfunction

   function automatic bit invalidate_all();
      // With nothing held and validity already false, a repeated drop only
      // clears the validity value and is not counted.
      if (!st_act_pres && !st_pend_pres && !(st_seen && st_val) && st_ever_inv) begin
         st_val = 1'b0;
         return 1'b0;
      end
      st_act_pres  = 1'b0;
      st_act_id    = '0;
      st_pend_pres = 1'b0;
      st_pend_id   = '0;
      st_val       = 1'b0;
      st_ever_inv  = 1'b1;
      st_gen       = st_gen + 1'b1;
      st_pend_gen  = '0;
      return 1'b1;
   endfunction

   function automatic bit promote_pending();
      if (!st_pend_pres || st_pend_gen != st_gen) return 1'b0;
      st_act_pres  = 1'b1;
      st_act_id    = st_pend_id;
      st_pend_pres = 1'b0;
      st_pend_id   = '0;
      st_pend_gen  = '0;
      return 1'b1;
   endfunction

   function automatic bit drop_when_stale(logic [TIME_W-1:0] now);
      if (st_seen && st_val && !fresh_at(now)) return invalidate_all();
      return 1'b0;
   endfunction

   function automatic holder_result_type predict_response(holder_req_type rq);
      holder_result_type   r;
      logic [HANDLE_W-1:0] id;
      logic [TIME_W-1:0]   ts;
      r  = '0;
      ts = rq.timestamp;
      id = rq.handle_present ? rq.handle_id : '0;
      case (rq.kind)
         fgph_pkg::KIND_SNAPSHOT: begin
            r.flags.invalidated = drop_when_stale(ts);
            if (fresh_at(ts)) begin
               st_act_pres  = rq.handle_present;
               st_act_id    = id;
               st_pend_pres = 1'b0;
               st_pend_id   = '0;
               st_pend_gen  = '0;
            end else begin
               st_pend_pres = rq.handle_present;
               st_pend_id   = id;
               st_pend_gen  = st_gen;
               st_act_pres  = 1'b0;
               st_act_id    = '0;
            end
         end
         fgph_pkg::KIND_VALIDITY: begin
            if (!rq.valid_flag) begin
               st_seen             = 1'b1;
               st_last_time        = ts;
               r.flags.invalidated = invalidate_all();
            end else begin
               r.flags.invalidated = drop_when_stale(ts);
               r.flags.stale_drop  = r.flags.invalidated;
               st_seen             = 1'b1;
               st_val              = 1'b1;
               st_last_time        = ts;
               r.flags.activated   = promote_pending();
            end
         end
         fgph_pkg::KIND_CHECK: r.flags.invalidated = drop_when_stale(ts);
         default: begin
            r.flags.invalidated = drop_when_stale(ts);
            if (fresh_at(ts)) begin
               void'(promote_pending());
               r.flags.out_present = st_act_pres;
               r.out_id            = st_act_pres ? st_act_id : '0;
            end
         end
      endcase
      r.flags.validity_seen = st_seen;
      r.flags.validity_set  = st_val;
      return r;
   endfunction

   function automatic void add_row(fgph_pkg::kind_type k, logic [TIME_W-1:0] ts, bit fl,
                                   bit pr, logic [HANDLE_W-1:0] id, bit typed = 1'b0,
                                   fgph_pkg::rsp_flags_type exp_flags = '0,
                                   logic [HANDLE_W-1:0] exp_id = '0);
      stim_row_type row;
      row.rq    = '{kind: k, timestamp: ts, valid_flag: fl, handle_present: pr, handle_id: id};
      row.typed = typed;
      row.rsp   = '{flags: exp_flags, out_id: exp_id};
      stim_table.push_back(row);
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   task automatic send_request(input holder_req_type rq, input bit typed,
                               input holder_result_type typed_rsp);
      holder_result_type predicted;
      int                gap;
      req_if.valid          <= 1'b1;
      req_if.kind           <= rq.kind;
      req_if.timestamp      <= rq.timestamp;
      req_if.valid_flag     <= rq.valid_flag;
      req_if.handle_present <= rq.handle_present;
      req_if.handle_id      <= rq.handle_id;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = predict_response(rq);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
      if (idle_on && $urandom_range(5, 0) == 0) begin
         gap = $urandom_range(19, 1);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and waits for every outstanding response; a nonzero tail keeps
   // valid from being raised in the step where it was lowered.
   task automatic drain_responses(input int tail);
      req_if.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [fgph_pkg::CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TIMEOUT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      st_timeout = value[TIME_W-1:0];
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random stalls plus one long hold-off that fills the pipeline.
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rx_long_stall) begin
            rx_long_stall = 1'b0;
            hold = LONG_STALL;
         end else if (idle_on && $urandom_range(7, 0) == 0) begin
            hold = $urandom_range(19, 1);
         end
         rsp_if.ready <= !reset && hold == 0;
      end
   end

   initial begin
      holder_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_rsps.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("invalidated", want.flags.invalidated, rsp_if.invalidated);
               check_field("stale_drop", want.flags.stale_drop, rsp_if.stale_drop);
               check_field("activated", want.flags.activated, rsp_if.activated);
               check_field("out_present", want.flags.out_present, rsp_if.out_present);
               check_field("out_id", want.out_id, rsp_if.out_id);
               check_field("validity_seen", want.flags.validity_seen,
                           rsp_if.validity_seen);
               check_field("validity_set", want.flags.validity_set, rsp_if.validity_set);
            end
         end
      end
   end

   initial begin
      holder_req_type                     rq;
      logic [TIME_W-1:0]                  span;
      logic [TIME_W-1:0]                  ts;
      logic [TIME_W-1:0]                  cur_time;
      logic [63:0]                        wide;
      logic [fgph_pkg::CSR_DATA_BITS-1:0] tmo_value;
      int                                 pick;

      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.kind           = fgph_pkg::KIND_SNAPSHOT;
      req_if.timestamp      = '0;
      req_if.valid_flag     = 1'b0;
      req_if.handle_present = 1'b0;
      req_if.handle_id      = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      cur_time              = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset nothing is held and no validity has been seen.
      add_row(fgph_pkg::KIND_READ, 48'd0, 1'b0, 1'b0, 16'h0000,
              1'b1, 6'b000000, 16'h0000);
      add_row(fgph_pkg::KIND_CHECK, TIME_MAX, 1'b1, 1'b1, 16'hFFFF,
              1'b1, 6'b000000, 16'h0000);
      add_row(fgph_pkg::KIND_SNAPSHOT, 48'd100, 1'b0, 1'b1, 16'hFFFF,
              1'b1, 6'b000000, 16'h0000);
      add_row(fgph_pkg::KIND_VALIDITY, 48'd100, 1'b1, 1'b0, 16'h0000,
              1'b1, 6'b001011, 16'h0000);
      // An age equal to the timeout is still fresh; one tick more is stale.
      add_row(fgph_pkg::KIND_READ, 48'd1000000100, 1'b0, 1'b0, 16'h0000,
              1'b1, 6'b000111, 16'hFFFF);
      add_row(fgph_pkg::KIND_READ, 48'd1000000101, 1'b0, 1'b0, 16'h0000,
              1'b1, 6'b100010, 16'h0000);
      // Nothing held and validity already false, so this drop is not a real one.
      add_row(fgph_pkg::KIND_VALIDITY, 48'd5, 1'b0, 1'b1, 16'h1111,
              1'b1, 6'b000010, 16'h0000);
      add_row(fgph_pkg::KIND_SNAPSHOT, 48'd6, 1'b0, 1'b0, 16'h1234);
      add_row(fgph_pkg::KIND_VALIDITY, 48'd10, 1'b1, 1'b0, 16'h0000);
      // A timestamp behind the last validity counts as stale.
      add_row(fgph_pkg::KIND_SNAPSHOT, 48'd9, 1'b0, 1'b1, 16'h00A5);
      add_row(fgph_pkg::KIND_VALIDITY, 48'd20, 1'b1, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_READ, 48'd25, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_SNAPSHOT, 48'd30, 1'b0, 1'b1, 16'h5A5A);
      add_row(fgph_pkg::KIND_READ, 48'd30, 1'b1, 1'b1, 16'hFFFF);
      add_row(fgph_pkg::KIND_SNAPSHOT, 48'd31, 1'b0, 1'b0, 16'hFFFF);
      add_row(fgph_pkg::KIND_READ, 48'd31, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_VALIDITY, 48'd2000000000, 1'b1, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_VALIDITY, TIME_MAX, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_VALIDITY, TIME_MAX, 1'b1, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_SNAPSHOT, TIME_MAX, 1'b0, 1'b1, 16'h0000);
      add_row(fgph_pkg::KIND_READ, TIME_MAX, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_READ, 48'd0, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_CHECK, 48'd0, 1'b0, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_VALIDITY, 48'd50, 1'b1, 1'b0, 16'h0000);
      add_row(fgph_pkg::KIND_CHECK, 48'd1000000051, 1'b0, 1'b0, 16'h0000);

      foreach (stim_table[r])
         send_request(stim_table[r].rq, stim_table[r].typed, stim_table[r].rsp);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_responses(4);
         idle_on = (phase < NUM_PHASES - 1);
         // The timeout register is 48 bits; the upper data bits carry junk.
         case (phase)
            1: tmo_value = '0;
            2: tmo_value = '1;
            3: tmo_value = 64'd250;
            4: begin
               tmo_value = {$urandom, $urandom};
               tmo_value[47:32] = '0;
            end
            5: tmo_value = {16'hA5A5, 48'd1000000000};
            default: tmo_value = fgph_pkg::TIMEOUT_RESET;
         endcase
         if (phase > 0) write_timeout(tmo_value);
         if (phase == 1) rx_long_stall = 1'b1;
         cur_time = st_last_time;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 2 && i == PHASE_ITEMS / 2) drain_responses(1);
            // Keep most timestamps near the last validity so that fresh,
            // boundary and stale cases all come up under every timeout.
            pick = $urandom_range(19, 0);
            if (pick < 12) begin
               span = st_timeout / 3 + 1;
               if (span > 48'hFFFF_FFFF) span = 48'hFFFF_FFFF;
               ts = cur_time + $urandom_range(span[31:0], 0);
            end else if (pick < 14) begin
               ts = cur_time - $urandom_range(1000, 1);
            end else if (pick < 16) begin
               ts = st_last_time + st_timeout + $urandom_range(1, 0);
            end else if (pick < 18) begin
               ts = cur_time;
            end else begin
               wide = {$urandom, $urandom};
               ts = wide[TIME_W-1:0];
            end
            cur_time = ts;
            pick = $urandom_range(99, 0);
            if (pick < 28)      rq.kind = fgph_pkg::KIND_SNAPSHOT;
            else if (pick < 58) rq.kind = fgph_pkg::KIND_VALIDITY;
            else if (pick < 70) rq.kind = fgph_pkg::KIND_CHECK;
            else                rq.kind = fgph_pkg::KIND_READ;
            rq.timestamp      = ts;
            rq.valid_flag     = $urandom_range(99, 0) < 80;
            rq.handle_present = $urandom_range(99, 0) < 85;
            rq.handle_id      = HANDLE_W'($urandom_range(65535, 0));
            send_request(rq, 1'b0, '0);
         end
      end

      drain_responses(10);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/fgph_pkg.sv
rtl/fgph_if.sv
rtl/fgph_csr.sv
rtl/fgph_core.sv
rtl/freshness_gated_path_holder_top.sv
tb/freshness_gated_path_holder_top_tb.sv
